/* sv/assert_macros.svh */
// Assertion helpers used by the checker file hsct_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset.
`define CHK_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");

// Implication whose consequent is checked at the next clock.
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");

`endif

/* sv/hsct_pkg.sv */
package hsct_pkg;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_INSERTED = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_DISABLED = 3'd4
	} status_t;

	localparam logic [0:0] REQ_RECORD = 1'b0;
	localparam logic [0:0] REQ_LOOKUP = 1'b1;

	localparam logic ADDR_THRESHOLD = 1'b0;
	localparam logic ADDR_ENABLE    = 1'b1;

	localparam logic [31:0] THRESHOLD_RESET = 32'd1000;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_HOME,
		S_READ,
		S_CHECK,
		S_DIV,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [0:0]  req_type;
		logic [47:0] node_key;
		logic [7:0]  node_kind;
		logic [23:0] line_number;
		logic [31:0] exec_time;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] exec_count;
		logic [47:0] total_time;
		logic [31:0] peak_time;
		logic [31:0] avg_time;
		logic        is_hot;
		logic        became_hot;
		logic [8:0]  hot_entries;
		logic [47:0] total_records;
	} rsp_t;

	// one stored entry: key, count, total, peak, hot
	typedef struct packed {
		logic [47:0] key;
		logic [31:0] count;
		logic [47:0] total;
		logic [31:0] peak;
		logic        hot;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/hsct_ram.sv */
module hsct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/hsct_div.sv */
// Restoring divider, one quotient bit per cycle, 48 by 32 bits.
module hsct_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [47:0] quotient
);
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted  = {rem_q[31:0], quo_q[47]};
	assign diff     = shifted - {1'b0, dsr_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule

/* sv/hot_spot_counter_table.sv */
// Hot spot counter table. A request (start while busy is low) is either a
// record or a lookup. The home slot is (kind*31 + line) mod TABLE_DEPTH,
// reduced by a registered reciprocal multiply for the quotient, then a
// registered multiply-subtract for the remainder, and slots are probed
// linearly, one slot at a time through the entry memory (read, then
// compare). When an entry is reported, the bit-serial average divider runs
// after the probing. busy stays high through the whole request, so no new
// request is taken before it ends. The result appears on rsp for one cycle
// with done high and cannot be stalled: the receiver must take it then. Valid
// bits live in flip-flops, cleared at reset, so no clearing pass is needed.
module hot_spot_counter_table #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hsct_pkg::req_t       req,
	output logic                 done,
	output hsct_pkg::rsp_t       rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import hsct_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	// hash is below 2^25; exact quotient via ceil(2^(25+LG)/depth)
	localparam int HW = 25;
	localparam int LG = $clog2(TABLE_DEPTH);
	localparam logic [26:0] RECIP = 27'(((64'd1 << (HW + LG)) + 64'(TABLE_DEPTH - 1))
		/ 64'(TABLE_DEPTH));
	localparam logic [24:0] DEPTH_C = 25'(TABLE_DEPTH);

	// config registers
	logic [31:0] thr_q;
	logic        en_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			en_q  <= 1'b1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ADDR_THRESHOLD) thr_q <= pwdata;
			else en_q <= pwdata[0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == ADDR_THRESHOLD) prdata = thr_q;
			else prdata = {31'd0, en_q};
		end
	end

	fsm_t state_q, state_d;
	req_t req_q;
	logic [HW-1:0] hash_q;
	logic [23:0] hquo_q;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] probes_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [8:0]  hot_q;
	logic [47:0] rec_q;
	rsp_t res_q;

	// memory
	logic          we;
	entry_t        wentry, rentry;
	logic [AW-1:0] raddr;

	hsct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(slot_q), .wdata(wentry),
		.raddr(raddr), .rdata(rentry)
	);

	// hash: kind*31 + line, then mod depth in two registered steps
	logic [HW-1:0] hash_sum;
	logic [51:0]   hprod;
	logic [23:0]   hquo;
	logic [HW-1:0] hrem;
	assign hash_sum = {17'd0, req.node_kind} * 25'd31 + {1'b0, req.line_number};
	assign hprod    = {27'd0, hash_q} * {25'd0, RECIP};
	assign hquo     = 24'(hprod >> (HW + LG));
	assign hrem     = hash_q - {1'b0, hquo_q} * DEPTH_C;

	assign raddr = slot_q;

	// check stage
	logic slot_vld, hit, miss_empty, exhausted;
	entry_t upd;
	logic [48:0] tot_sum;
	logic now_hot;
	rsp_t chk_res;
	assign slot_vld   = valid_q[slot_q];
	assign hit        = slot_vld && rentry.key == req_q.node_key;
	assign miss_empty = !slot_vld;
	assign exhausted  = probes_q == CW'(TABLE_DEPTH - 1);

	// divider for the average, loaded with the counters being reported
	logic        div_go, div_done;
	logic [47:0] div_q;
	hsct_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.dividend(chk_res.total_time), .divisor(chk_res.exec_count),
		.done(div_done), .quotient(div_q)
	);

	always_comb begin
		entry_t b;
		b = rentry;
		if (!slot_vld) begin
			b = '0;
			b.key = req_q.node_key;
		end
		upd = b;
		if (b.count != MAX32) upd.count = b.count + 32'd1;
		tot_sum = {1'b0, b.total} + {17'd0, req_q.exec_time};
		upd.total = tot_sum[48] ? MAX48 : tot_sum[47:0];
		if (req_q.exec_time > b.peak) upd.peak = req_q.exec_time;
		now_hot = !b.hot && upd.count >= thr_q;
		if (now_hot) upd.hot = 1'b1;
	end
	assign wentry = upd;

	// result of one compare; the last probe's value is the one kept
	always_comb begin
		chk_res = '0;
		if (req_q.req_type == REQ_RECORD && !en_q) begin
			chk_res.status = ST_DISABLED;
		end else if (req_q.req_type == REQ_LOOKUP) begin
			if (hit) begin
				chk_res.status     = ST_FOUND;
				chk_res.exec_count = rentry.count;
				chk_res.total_time = rentry.total;
				chk_res.peak_time  = rentry.peak;
				chk_res.is_hot     = rentry.hot;
			end else begin
				chk_res.status = ST_NOTFOUND;
			end
		end else if (hit || miss_empty) begin
			chk_res.status     = hit ? ST_FOUND : ST_INSERTED;
			chk_res.exec_count = upd.count;
			chk_res.total_time = upd.total;
			chk_res.peak_time  = upd.peak;
			chk_res.is_hot     = upd.hot;
			chk_res.became_hot = now_hot;
		end else begin
			chk_res.status = ST_FULL;
		end
	end

	logic do_write;
	assign do_write = state_q == S_CHECK && req_q.req_type == REQ_RECORD && en_q
		&& (hit || miss_empty);
	assign we = do_write;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_HASH;
			S_HASH: state_d = S_HOME;
			S_HOME: state_d = S_READ;
			S_READ: state_d = S_CHECK;
			S_CHECK: begin
				if (req_q.req_type == REQ_RECORD && !en_q) state_d = S_DONE;
				else if (hit || (miss_empty && req_q.req_type == REQ_RECORD))
					state_d = S_DIV;
				else if (miss_empty || exhausted) state_d = S_DONE;
				else state_d = S_READ;
			end
			S_DIV: if (div_done) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy   = state_q != S_IDLE;
	assign done   = state_q == S_DONE;
	assign div_go = state_q == S_CHECK && state_d == S_DIV;

	always_comb begin
		rsp = res_q;
		rsp.hot_entries   = hot_q;
		rsp.total_records = rec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			hot_q   <= '0;
			rec_q   <= '0;
		end else begin
			state_q <= state_d;
			if (do_write) begin
				valid_q[slot_q] <= 1'b1;
				if (now_hot) hot_q <= hot_q + 9'd1;
				if (rec_q != MAX48) rec_q <= rec_q + 48'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q    <= req;
			hash_q   <= hash_sum;
			probes_q <= '0;
		end else if (state_q == S_HASH) begin
			hquo_q <= hquo;
		end else if (state_q == S_HOME) begin
			slot_q <= hrem[AW-1:0];
		end else if (state_q == S_CHECK) begin
			res_q    <= chk_res;
			slot_q   <= (slot_q == AW'(TABLE_DEPTH - 1)) ? '0 : slot_q + AW'(1);
			probes_q <= probes_q + CW'(1);
		end else if (state_q == S_DIV && div_done) begin
			if (res_q.exec_count == '0) res_q.avg_time <= '0;
			else if (div_q[47:32] != '0) res_q.avg_time <= MAX32;
			else res_q.avg_time <= div_q[31:0];
		end
	end
endmodule

/* sv/hsct_checker.sv */
`include "assert_macros.svh"
module hsct_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	`CHK_IMPLY(a_done_busy, clk, arst_n, done, busy)
	`CHK_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`CHK_NEXT(a_done_once, clk, arst_n, done, !done)
endmodule

bind hot_spot_counter_table hsct_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
